[sv/swk_pkg.sv]
// Package for the three-wheel swerve kinematics core: types, constants, tables.
`timescale 1ns / 1ps
`default_nettype none
package swk_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int STEPS_EFF    = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  localparam int XW = 29;   // CORDIC x/y width
  localparam int ZW = 26;   // angle accumulator width, 1/65536 degree
  localparam int CW = 18;   // wheel vector component width
  localparam int SW = 5;    // shift amount width

  localparam logic signed [ZW-1:0] DEG180 = 26'sd11796480;
  localparam logic [63:0] INV_GAIN_BASE = 64'd2608131496;
  localparam logic [63:0] INV_GAIN_CORR = 64'd1738754331;
  localparam logic [63:0] INV_GAIN_64   = INV_GAIN_BASE + (INV_GAIN_CORR >> (2 * STEPS_EFF));
  localparam logic [31:0] INV_GAIN      = INV_GAIN_64[31:0];

  localparam logic [7:0] REG_WHEEL_RADIUS = 8'd0;
  localparam logic [7:0] REG_DEAD_ZONE    = 8'd1;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero_ang;
  } vec_t;

  function automatic logic signed [ZW-1:0] atan_at(input int i);
    logic signed [ZW-1:0] v;
    unique case (i)
      0: v = 26'sd2949120;   1: v = 26'sd1740967;   2: v = 26'sd919879;
      3: v = 26'sd466945;    4: v = 26'sd234379;    5: v = 26'sd117304;
      6: v = 26'sd58666;     7: v = 26'sd29335;     8: v = 26'sd14668;
      9: v = 26'sd7334;      10: v = 26'sd3667;     11: v = 26'sd1833;
      12: v = 26'sd917;      13: v = 26'sd458;      14: v = 26'sd229;
      15: v = 26'sd115;      16: v = 26'sd57;       17: v = 26'sd29;
      18: v = 26'sd14;       19: v = 26'sd7;        20: v = 26'sd4;
      21: v = 26'sd2;        22: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Scale a wheel vector by 256, fold the left half plane and flag the dead zone.
  function automatic vec_t mk_vec(input logic signed [CW-1:0] x,
                                  input logic signed [CW-1:0] y,
                                  input logic [7:0] dz);
    vec_t v;
    logic signed [XW-1:0] cx, cy;
    logic [CW-1:0] ax, ay;
    cx = {{(XW-CW-8){x[CW-1]}}, x, 8'd0};
    cy = {{(XW-CW-8){y[CW-1]}}, y, 8'd0};
    ax = x[CW-1] ? CW'(-x) : CW'(x);
    ay = y[CW-1] ? CW'(-y) : CW'(y);
    v.zero_ang = ((x == '0) && (y == '0)) ||
                 ((ax < {{(CW-8){1'b0}}, dz}) && (ay < {{(CW-8){1'b0}}, dz}));
    if (x[CW-1]) begin
      v.z = y[CW-1] ? -DEG180 : DEG180;
      v.x = -cx;
      v.y = -cy;
    end else begin
      v.z = '0;
      v.x = cx;
      v.y = cy;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

[sv/swk_cell.sv]
// One CORDIC vectoring cell: a single micro-rotation, registered.
`timescale 1ns / 1ps
`default_nettype none
module swk_cell
  import swk_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [SW-1:0]        shift,
  input  wire logic signed [ZW-1:0] atan,
  input  wire vec_t                 d,
  output vec_t                      q
);
  vec_t q_next;
  logic signed [XW-1:0] dx, dy;

  always_comb begin
    dx = d.y >>> shift;
    dy = d.x >>> shift;
    q_next = d;
    if (!d.y[XW-1]) begin
      q_next.x = d.x + dx;
      q_next.y = d.y - dy;
      q_next.z = d.z + atan;
    end else begin
      q_next.x = d.x - dx;
      q_next.y = d.y + dy;
      q_next.z = d.z - atan;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= q_next;
  end
endmodule
`default_nettype wire

[sv/swk_post.sv]
// Gain removal, rounding and angle wrap for one wheel, two register stages.
`timescale 1ns / 1ps
`default_nettype none
module swk_post
  import swk_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         en,
  input  wire vec_t         d,
  output logic [16:0]       speed,
  output logic signed [15:0] angle
);
  logic [59:0]          prod;
  logic signed [ZW-1:0] z1;
  logic                 zero1;
  logic [XW-2:0]        mag;
  logic [20:0]          sp_r;
  logic signed [ZW-1:0] zr;
  logic signed [17:0]   a, r, r_w;
  logic [16:0]          speed_next;
  logic signed [15:0]   angle_next;

  assign mag = d.x[XW-1] ? '0 : d.x[XW-2:0];

  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= 60'(mag) * 60'(INV_GAIN);
      z1    <= d.z;
      zero1 <= d.zero_ang;
    end
  end

  always_comb begin
    sp_r = 21'((prod + (60'd1 << 39)) >> 40);
    speed_next = (sp_r > 21'd131071) ? 17'd131071 : sp_r[16:0];
    zr = z1 + 26'sd256;
    a  = 18'(zr >>> 9);
    r  = 18'sd11520 - a;
    if (r > 18'sd23040)        r_w = r - 18'sd46080;
    else if (r <= -18'sd23040) r_w = r + 18'sd46080;
    else                       r_w = r;
    angle_next = zero1 ? 16'sd0 : r_w[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      speed <= speed_next;
      angle <= angle_next;
    end
  end
endmodule
`default_nettype wire

[sv/three_wheel_swerve_kinematics_core.sv]
// Top level of the three-wheel swerve drive inverse kinematics core.
`timescale 1ns / 1ps
`default_nettype none
// Takes one chassis command per cycle (vel_x, vel_y, rot_rate) and returns per wheel a rounded
// speed and a steering angle in 1/128 degree, wrapped into (-180, 180]. Stages in order:
// input register, radius multiply, wheel constant multiply, vector forming, one CORDIC cell
// per step, gain multiply and the output register. One item enters per cycle; a stall on the
// result side holds the whole pipeline. Registers: index 0 wheel_radius (12 bits), index 1
// dead_zone (8 bits); writes are always accepted, other indexes are dropped.
module three_wheel_swerve_kinematics_core
  import swk_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [47:0]  s_tdata,   // vel_x[15:0], vel_y[31:16], rot_rate[47:32]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // speed_one[16:0], angle_one[32:17], speed_two[49:33], angle_two[65:50],
  // speed_three[82:66], angle_three[98:83], zero pad [103:99]
  output logic [103:0]      m_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_index,
  input  wire logic [11:0]  cfg_data
);
  localparam int LAT = STEPS_EFF + 6;

  logic [11:0] wheel_radius;
  logic [7:0]  dead_zone;
  logic        en, s_acc;
  logic [LAT-1:0] pipe_vld;

  // advance the whole pipeline whenever the output slot is free or being taken
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign s_acc    = s_tvalid && en;
  assign cfg_ready = 1'b1;
  assign m_tvalid = pipe_vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_radius <= 12'd100;
      dead_zone    <= 8'd1;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WHEEL_RADIUS) wheel_radius <= cfg_data;
      else if (cfg_index == REG_DEAD_ZONE) dead_zone <= cfg_data[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pipe_vld <= '0;
    else if (en) pipe_vld <= {pipe_vld[LAT-2:0], s_acc};
  end

  // stage 1: register the command
  logic signed [15:0] vx1, vy1, vr1;
  always_ff @(posedge clk) begin
    if (en) begin
      vx1 <= s_tdata[15:0];
      vy1 <= s_tdata[31:16];
      vr1 <= s_tdata[47:32];
    end
  end

  // stage 2: tangential velocity vrr = floor(rot_rate * radius / 4096)
  logic signed [28:0] rprod;
  logic signed [16:0] vrr2;
  logic signed [15:0] vx2, vy2;
  assign rprod = 29'(vr1) * 29'($signed({1'b0, wheel_radius}));
  always_ff @(posedge clk) begin
    if (en) begin
      vrr2 <= rprod[28:12];
      vx2  <= vx1;
      vy2  <= vy1;
    end
  end

  // stage 3: half and sqrt(3)/2 shares of vrr
  logic signed [32:0] sprod;
  logic signed [16:0] vrr3, h3;
  logic signed [17:0] s3;
  logic signed [15:0] vx3, vy3;
  assign sprod = 33'(vrr2) * 33'sd28378;
  always_ff @(posedge clk) begin
    if (en) begin
      vrr3 <= vrr2;
      h3   <= vrr2 >>> 1;
      s3   <= sprod[32:15];
      vx3  <= vx2;
      vy3  <= vy2;
    end
  end

  // stage 4: form the three wheel vectors and fold them into the right half plane
  logic signed [CW-1:0] x1, y1, x2, y2, y3;
  vec_t chain [STEPS_EFF+1][3];
  always_comb begin
    x1 = CW'(vx3) - CW'(vrr3);
    y1 = CW'(vy3);
    x2 = CW'(vx3) + CW'(h3);
    y2 = CW'(vy3) + s3;
    y3 = CW'(vy3) - s3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      chain[0][0] <= mk_vec(x1, y1, dead_zone);
      chain[0][1] <= mk_vec(x2, y2, dead_zone);
      chain[0][2] <= mk_vec(x2, y3, dead_zone);
    end
  end

  // CORDIC row: one cell per step and wheel
  for (genvar k = 0; k < STEPS_EFF; k++) begin : g_step
    for (genvar w = 0; w < 3; w++) begin : g_wheel
      swk_cell u_cell (
        .clk   (clk),
        .en    (en),
        .shift (SW'(k)),
        .atan  (atan_at(k)),
        .d     (chain[k][w]),
        .q     (chain[k+1][w])
      );
    end
  end

  logic [16:0] spd [3];
  logic signed [15:0] ang [3];
  for (genvar w = 0; w < 3; w++) begin : g_post
    swk_post u_post (
      .clk   (clk),
      .en    (en),
      .d     (chain[STEPS_EFF][w]),
      .speed (spd[w]),
      .angle (ang[w])
    );
  end

  assign m_tdata = {5'd0, ang[2], spd[2], ang[1], spd[1], ang[0], spd[0]};

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");
  a_cfg_radius: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_index == REG_WHEEL_RADIUS |=> wheel_radius == $past(cfg_data))
    else $error("wheel_radius write lost");
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(ang[0]) > -16'sd23040 && $signed(ang[0]) <= 16'sd23040)
    else $error("angle_one out of range");
endmodule
`default_nettype wire

[test/tb.sv]
// Testbench for the three-wheel swerve kinematics core: prediction and checks of wheel results.
`timescale 1ns / 1ps
module tb;
  import swk_pkg::*;

  localparam int PIPE_DELAY = CORDIC_STEPS + 6;  // depth of the core pipeline
  localparam int DRAIN_WAIT = PIPE_DELAY + 10;
  localparam int STALL_LIMIT = 20000;

  // One command item as it travels on s_tdata.
  typedef struct packed {
    logic signed [15:0] rot_rate;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_x;
  } cmd_t;

  // One result item: speed and steering angle per wheel.
  typedef struct {
    logic [16:0]        spd[3];
    logic signed [15:0] ang[3];
  } wheels_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [11:0]  cfg_data = '0;

  // Shadow copy of the core registers.
  logic [11:0] radius_q = 12'd100;
  logic [7:0]  dzone_q  = 8'd1;

  cmd_t    pending_cmds[$];
  wheels_t wheels_due[$];
  int      mismatches = 0;
  int      cmds_sent = 0;
  int      results_seen = 0;
  int      cyc = 0;
  int      quiet_cycles = 0;
  bit      cmd_taken = 1'b0;

  longint atan_lut[TABLE_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  three_wheel_swerve_kinematics_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Run the vectoring CORDIC on one wheel vector; return speed and angle.
  task automatic solve_wheel(input longint x, input longint y,
                             output logic [16:0] spd, output logic signed [15:0] ang);
    longint cx, cy, z, dx, dy, a, r;
    longint unsigned inv, sp;
    cx = x * 256;
    cy = y * 256;
    z = 0;
    if (cx < 0) begin
      z = (cy >= 0) ? 11796480 : -11796480;
      cx = -cx;
      cy = -cy;
    end
    for (int i = 0; i < STEPS_EFF; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += atan_lut[i];
      end else begin
        cx -= dx; cy += dy; z -= atan_lut[i];
      end
    end
    if (cx < 0) cx = 0;
    inv = 64'd2608131496 + (64'd1738754331 >> (2 * STEPS_EFF));
    sp = (longint'(unsigned'(cx)) * inv + (64'd1 << 39)) >> 40;
    if (sp > 131071) sp = 131071;
    spd = sp[16:0];
    // Force the angle to zero inside the dead zone and for the zero vector.
    if ((x == 0 && y == 0) ||
        ((x < 0 ? -x : x) < dzone_q && (y < 0 ? -y : y) < dzone_q)) begin
      ang = '0;
    end else begin
      a = (z + 256) >>> 9;
      r = 11520 - a;
      if (r > 23040) r -= 46080;
      else if (r <= -23040) r += 46080;
      ang = r[15:0];
    end
  endtask

  task automatic predict_wheels(input cmd_t c, output wheels_t w);
    longint vx, vy, vrr, h, s;
    vx = c.vel_x;
    vy = c.vel_y;
    vrr = (longint'(c.rot_rate) * longint'(radius_q)) >>> 12;
    h = (vrr * 16384) >>> 15;
    s = (vrr * 28378) >>> 15;
    solve_wheel(vx - vrr, vy, w.spd[0], w.ang[0]);
    solve_wheel(vx + h, vy + s, w.spd[1], w.ang[1]);
    solve_wheel(vx + h, vy - s, w.spd[2], w.ang[2]);
  endtask

  function automatic logic [15:0] rand_field(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(600) - 300);
      default: begin
        case ($urandom_range(4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'hffff;
          default: return 16'($urandom_range(4) - 2);
        endcase
      end
    endcase
  endfunction

  // No idling on either side in this cycle window.
  function automatic bit busy_stretch();
    return cyc >= 1500 && cyc < 2500;
  endfunction

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Command driver: predict on acceptance, refill at the falling edge.
  always @(posedge clk) begin
    wheels_t w;
    if (!rst && s_tvalid && s_tready) begin
      predict_wheels(cmd_t'(s_tdata), w);
      wheels_due.push_back(w);
      cmds_sent++;
      cmd_taken = 1'b1;
    end
    if (!rst && cfg_valid && cfg_ready) begin
      if (cfg_index == REG_WHEEL_RADIUS) radius_q <= cfg_data;
      else if (cfg_index == REG_DEAD_ZONE) dzone_q <= cfg_data[7:0];
    end
  end

  always @(negedge clk) begin
    if (!s_tvalid || cmd_taken) begin
      cmd_taken = 1'b0;
      if (!rst && pending_cmds.size() > 0 &&
          (busy_stretch() || $urandom_range(99) >= 36)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_cmds.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor: random back-pressure, compare with the oldest prediction.
  always @(negedge clk) begin
    m_tready <= !rst && (busy_stretch() || $urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    wheels_t w;
    logic [16:0] got_spd;
    logic signed [15:0] got_ang;
    bit bad;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (wheels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item %h", m_tdata);
      end else begin
        w = wheels_due.pop_front();
        bad = 1'b0;
        for (int k = 0; k < 3; k++) begin
          got_spd = m_tdata[33*k +: 17];
          got_ang = m_tdata[33*k + 17 +: 16];
          if (got_spd !== w.spd[k] || got_ang !== w.ang[k]) begin
            bad = 1'b1;
            if (mismatches < 10)
              $display("Wheel %0d mismatch: speed exp %0d got %0d, angle exp %0d got %0d",
                       k + 1, w.spd[k], got_spd, w.ang[k], got_ang);
          end
        end
        if (bad) mismatches++;
      end
    end
  end

  task automatic write_reg(input logic [7:0] idx, input logic [11:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold off until every command has been taken and every result has come.
  task automatic drain();
    while (pending_cmds.size() > 0 || s_tvalid || wheels_due.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic push_cmd(input logic [15:0] vx, input logic [15:0] vy, input logic [15:0] vr);
    cmd_t c;
    c.vel_x = vx;
    c.vel_y = vy;
    c.rot_rate = vr;
    pending_cmds.push_back(c);
  endtask

  initial begin
    int mode;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, zero vector, half-plane folds, dead zone edges.
    write_reg(REG_WHEEL_RADIUS, 12'd100);
    write_reg(REG_DEAD_ZONE, 12'd1);
    push_cmd(16'h0000, 16'h0000, 16'h0000);
    push_cmd(16'h7fff, 16'h7fff, 16'h7fff);
    push_cmd(16'h8000, 16'h8000, 16'h8000);
    push_cmd(16'h8000, 16'h7fff, 16'h7fff);
    push_cmd(16'h7fff, 16'h8000, 16'h8000);
    push_cmd(16'hffff, 16'h0000, 16'h0000);   // negative x on the axis: +180 start
    push_cmd(16'hff00, 16'hffff, 16'h0000);   // negative x, y just below zero
    push_cmd(16'h0000, 16'h0001, 16'h0000);
    push_cmd(16'h0000, 16'hffff, 16'h0000);
    push_cmd(16'h0001, 16'h0000, 16'h0000);
    push_cmd(16'h0000, 16'h0000, 16'h1000);   // pure rotation
    push_cmd(16'h0000, 16'h0000, 16'hf000);
    push_cmd(16'h8000, 16'h0000, 16'h0000);
    push_cmd(16'h0000, 16'h8000, 16'h0000);
    drain();

    // Dead zone 255 and radius extreme.
    write_reg(REG_WHEEL_RADIUS, 12'd4095);
    write_reg(REG_DEAD_ZONE, 12'd255);
    push_cmd(16'd254, 16'd254, 16'h0000);
    push_cmd(16'd255, 16'd0, 16'h0000);
    push_cmd(16'hff02, 16'hff02, 16'h0000);
    push_cmd(16'h7fff, 16'h7fff, 16'h8000);
    push_cmd(16'h8000, 16'h8000, 16'h7fff);
    drain();

    // Zero radius and zero dead zone, zero vector still gives angle zero.
    write_reg(REG_WHEEL_RADIUS, 12'd0);
    write_reg(REG_DEAD_ZONE, 12'd0);
    write_reg(8'd7, 12'hfff);                 // unknown index: dropped
    push_cmd(16'h0000, 16'h0000, 16'h7fff);
    push_cmd(16'h0003, 16'hfffd, 16'h8000);
    drain();

    // Random phases across several register settings.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_WHEEL_RADIUS, 12'd100); write_reg(REG_DEAD_ZONE, 12'd1); end
        1: begin write_reg(REG_WHEEL_RADIUS, 12'd4095); write_reg(REG_DEAD_ZONE, 12'd255); end
        2: begin write_reg(REG_WHEEL_RADIUS, 12'd0); write_reg(REG_DEAD_ZONE, 12'd0); end
        default: begin
          write_reg(REG_WHEEL_RADIUS, 12'($urandom));
          write_reg(REG_DEAD_ZONE, 12'($urandom_range(255)));
        end
      endcase
      for (int n = 0; n < 400; n++) begin
        mode = $urandom_range(2);
        push_cmd(rand_field(mode), rand_field(mode),
                 ($urandom_range(3) == 0) ? 16'h0000 : rand_field($urandom_range(2)));
      end
      drain();
    end

    $display("Covered %0d commands, %0d results over several radius and dead zone settings",
             cmds_sent, results_seen);
    if (mismatches == 0 && wheels_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Mismatches: %0d, results still due: %0d", mismatches, wheels_due.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
